[rtl/tcfls_pkg.sv]
package tcfls_pkg;

	// Input item kinds carried on s_tuser
	typedef enum logic [1:0] {
		OP_LOAD_ROW    = 2'd0,
		OP_LOAD_VERTEX = 2'd1,
		OP_RUN         = 2'd2
	} op_t;

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	localparam int ROW_W   = 64;
	localparam int VIDX_W  = 6;
	localparam int VCNT_W  = 7;
	localparam int FLIP_W  = 12;
	localparam int SCORE_W = 8;

	localparam logic [FLIP_W-1:0] FLIP_LIMIT = 12'd4095;

endpackage

[rtl/two_cluster_flip_local_search.sv]
// Load items (adjacency row, vertex label/fixed flag) are taken one per cycle, back to
// back, while idle. A run makes passes that each scan the in-use vertices (n adjacency
// rows read for an unfixed vertex, a fixed one skipped) and then decide, and finally
// streams out n results; passes = flips + 1, or flips when stopped at the 4095 flip cap.
// Input stays not ready from the run item until the last result is registered.
// The shared score accumulator reads one adjacency row per cycle from the row memory.
// arst_n clears labels, fixed flags, flip count, vertex_count (to 64) and all control;
// the adjacency memory is not cleared.
module two_cluster_flip_local_search #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [tcfls_pkg::VCNT_W-1:0]    cfg_wdata,  // vertex_count
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [71:0]                     s_tdata,    // vertex_index, adjacency_row,
	                                                    // initial_label, fixed_flag
	input  logic [1:0]                      s_tuser,    // operation
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,    // result_vertex, final_label,
	                                                    // flip_total, zero pad
	output logic                            m_tlast     // last_of_run
);

	import tcfls_pkg::*;

	localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	// Input unpacking
	logic [VIDX_W-1:0] in_vertex;
	logic [ROW_W-1:0]  in_row;
	logic              in_label;
	logic              in_fixed;
	logic              in_accept;
	logic              in_range;
	logic [IDX_W-1:0]  in_idx;

	assign in_vertex = s_tdata[5:0];
	assign in_row    = s_tdata[69:6];
	assign in_label  = s_tdata[70];
	assign in_fixed  = s_tdata[71];
	assign in_accept = s_tvalid && s_tready;
	assign in_range  = ({1'b0, in_vertex} < VCNT_W'(MAX_VERTICES));
	assign in_idx    = in_vertex[IDX_W-1:0];

	// State
	state_t                   state_q;
	logic [VCNT_W-1:0]        vertex_count_q;
	logic [MAX_VERTICES-1:0]  label_q;
	logic [MAX_VERTICES-1:0]  fixed_q;
	logic [MAX_VERTICES-1:0]  work_q;
	logic [FLIP_W-1:0]        flips_q;
	logic [IDX_W-1:0]         last_q;
	logic [IDX_W-1:0]         v_q;
	logic [IDX_W-1:0]         j_q;
	logic                     issue_q;
	logic signed [SCORE_W-1:0] score_q;
	logic signed [SCORE_W-1:0] best_q;
	logic [IDX_W-1:0]         cand_q;
	logic                     found_q;
	logic [IDX_W-1:0]         e_q;

	// Row memory read stage
	logic [MAX_VERTICES-1:0]  adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]  row_s1;
	logic                     rd_valid_s1;
	logic [IDX_W-1:0]         j_s1;
	logic                     last_s1;

	// Output register
	logic              m_tvalid_q;
	logic [IDX_W-1:0]  out_vertex_q;
	logic              out_label_q;
	logic [FLIP_W-1:0] out_flips_q;
	logic              out_last_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_flips_q, out_label_q, VIDX_W'(out_vertex_q)};

	// Clamp vertex_count to the used range, as a last index
	logic [VCNT_W-1:0] run_last;
	always_comb begin
		priority if (vertex_count_q == '0)
			run_last = '0;
		else if (vertex_count_q > VCNT_W'(MAX_VERTICES))
			run_last = VCNT_W'(MAX_VERTICES - 1);
		else
			run_last = vertex_count_q - VCNT_W'(1);
	end

	// Shared score unit: one row contribution per cycle
	logic                      same_c;
	logic                      joined_c;
	logic signed [SCORE_W-1:0] delta_c;
	logic signed [SCORE_W-1:0] score_c;
	logic                      better_c;

	always_comb begin
		same_c   = (work_q[j_s1] == work_q[v_q]);
		joined_c = row_s1[v_q];
		if (j_s1 == v_q)
			delta_c = '0;
		else if (same_c ^ joined_c)
			delta_c = SCORE_W'(1);
		else
			delta_c = -SCORE_W'(1);
		score_c  = score_q + delta_c;
		better_c = !found_q || (score_c > best_q);
	end

	logic slot_free;
	assign slot_free = !m_tvalid_q || m_tready;

	// Row memory write and registered read
	always_ff @(posedge clk) begin
		if (in_accept && (op_t'(s_tuser) == OP_LOAD_ROW) && in_range)
			adj_mem[in_idx] <= in_row[MAX_VERTICES-1:0];
		if (state_q == ST_SCAN && issue_q && !fixed_q[v_q])
			row_s1 <= adj_mem[j_q];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vertex_count_q <= VCNT_W'(64);
			label_q        <= '0;
			fixed_q        <= '0;
			work_q         <= '0;
			flips_q        <= '0;
			last_q         <= '0;
			v_q            <= '0;
			j_q            <= '0;
			issue_q        <= 1'b0;
			score_q        <= '0;
			best_q         <= '0;
			cand_q         <= '0;
			found_q        <= 1'b0;
			e_q            <= '0;
			rd_valid_s1    <= 1'b0;
			j_s1           <= '0;
			last_s1        <= 1'b0;
			m_tvalid_q     <= 1'b0;
			out_vertex_q   <= '0;
			out_label_q    <= 1'b0;
			out_flips_q    <= '0;
			out_last_q     <= 1'b0;
		end else begin
			if (cfg_wen)
				vertex_count_q <= cfg_wdata;

			rd_valid_s1 <= 1'b0;
			last_s1     <= 1'b0;

			// Release the output register once taken
			if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						unique case (op_t'(s_tuser))
							OP_LOAD_VERTEX: begin
								if (in_range) begin
									label_q[in_idx] <= in_label;
									fixed_q[in_idx] <= in_fixed;
								end
							end
							OP_RUN: begin
								last_q  <= run_last[IDX_W-1:0];
								work_q  <= label_q;
								flips_q <= '0;
								v_q     <= '0;
								j_q     <= '0;
								score_q <= '0;
								issue_q <= 1'b1;
								found_q <= 1'b0;
								state_q <= ST_SCAN;
							end
							default: begin
								// row loads go to memory; unused code is dropped
							end
						endcase
					end
				end

				ST_SCAN: begin
					// Finish a vertex: compare its score, then advance
					if (rd_valid_s1) begin
						score_q <= score_c;
						if (last_s1) begin
							if (better_c) begin
								found_q <= 1'b1;
								best_q  <= score_c;
								cand_q  <= v_q;
							end
							if (v_q == last_q) begin
								state_q <= ST_DECIDE;
							end else begin
								v_q     <= v_q + IDX_W'(1);
								j_q     <= '0;
								score_q <= '0;
								issue_q <= 1'b1;
							end
						end
					end
					// Skip a fixed vertex, or issue the next row read
					if (issue_q) begin
						if (fixed_q[v_q]) begin
							if (v_q == last_q) begin
								issue_q <= 1'b0;
								state_q <= ST_DECIDE;
							end else begin
								v_q <= v_q + IDX_W'(1);
							end
						end else begin
							rd_valid_s1 <= 1'b1;
							j_s1        <= j_q;
							last_s1     <= (j_q == last_q);
							if (j_q == last_q)
								issue_q <= 1'b0;
							else
								j_q <= j_q + IDX_W'(1);
						end
					end
				end

				ST_DECIDE: begin
					if (found_q && (best_q > 0)) begin
						work_q[cand_q] <= ~work_q[cand_q];
						flips_q        <= flips_q + FLIP_W'(1);
						if (flips_q + FLIP_W'(1) == FLIP_LIMIT) begin
							e_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							v_q     <= '0;
							j_q     <= '0;
							score_q <= '0;
							issue_q <= 1'b1;
							found_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end else begin
						e_q     <= '0;
						state_q <= ST_EMIT;
					end
				end

				ST_EMIT: begin
					// Stream one vertex label per free output slot
					if (slot_free) begin
						m_tvalid_q   <= 1'b1;
						out_vertex_q <= e_q;
						out_label_q  <= work_q[e_q];
						out_flips_q  <= flips_q;
						out_last_q   <= (e_q == last_q);
						if (e_q == last_q)
							state_q <= ST_IDLE;
						else
							e_q <= e_q + IDX_W'(1);
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
